// ===== hdl/gmds_pkg.sv =====
// ----------------------------------------------------------------------------
// gmds_pkg: shared types and constants of the depth-first maze solver
// Holds grid and stack sizes, the command codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gmds_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int STACK_DEPTH = 1024;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int CELL_W      = ROW_W + COL_W;
    localparam int SP_W        = 10;
    localparam int STEP_W      = 21;
    localparam logic [STEP_W-1:0] STEP_LIMIT = 21'h100000;
    localparam logic [SP_W-1:0]   SP_FULL    = SP_W'(STACK_DEPTH - 1);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_SOLVE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_HEIGHT    = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_ENTRY_ROW = 2'd2,
        REG_ENTRY_COL = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR_CELL,
        ST_CLEAR,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_EXAM,
        ST_NBR_RD,
        ST_NBR_WAIT,
        ST_NBR_CHK,
        ST_PUSH_CHOSEN,
        ST_PUSH_ALT,
        ST_ALT_RD,
        ST_ALT_WAIT,
        ST_UNW_RD,
        ST_UNW_WAIT,
        ST_UNW_CHK,
        ST_PUSH_TGT,
        ST_RDP_RD,
        ST_RDP_WAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/grid_maze_dfs_solver.sv =====
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver: depth-first maze solver with a loadable wall grid
// Cell writes, a sequenced depth-first search and path readback.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | mode, cell_row, cell_col, wall, path_index
//  out     | output    | o_out_valid/i_out_ready| found, path_length, path_row, path_col, overflow
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  An unused mode goes straight to the result, a cell write fetches the row
//  and then updates it, and a path read reads the path memory. A solve first
//  sweeps every cell of the on-path count memory, one cell a cycle, then per
//  search step fetches and tests the top, tests each neighbour (with no memory
//  read for one off the grid) and pushes, and for each popped alternative
//  examines path entries during the unwind and then pushes it.
//  Synchronous reset clears control state and the wall grid is cleared by
//  per-row valid bits. The result sits in an output register; the block takes
//  no transaction until it has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_dfs_solver
    import gmds_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_mode,
    input  wire logic [ROW_W-1:0]  i_cell_row,
    input  wire logic [COL_W-1:0]  i_cell_col,
    input  wire logic              i_wall,
    input  wire logic [SP_W-1:0]   i_path_index,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_found,
    output logic [SP_W-1:0]        o_path_length,
    output logic [ROW_W-1:0]       o_path_row,
    output logic [COL_W-1:0]       o_path_col,
    output logic                   o_overflow,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data
);

    // ---------------- state ----------------
    t_state r_state, n_state;
    logic [6:0]        r_height, r_width;
    logic [ROW_W-1:0]  r_entry_row;
    logic [COL_W-1:0]  r_entry_col;
    logic [MAX_ROWS-1:0] r_row_valid;
    logic [SP_W-1:0]   r_path_top, r_alt_top;
    logic              r_found, r_overflow;
    logic [STEP_W-1:0] r_steps;
    logic [ROW_W-1:0]  r_cur_row;      // top of path
    logic [COL_W-1:0]  r_cur_col;
    logic [1:0]        r_dir;          // neighbour under test
    logic [3:0]        r_ok;
    logic [ROW_W-1:0]  r_tgt_row;      // alternative being resumed
    logic [COL_W-1:0]  r_tgt_col;
    logic [CELL_W-1:0] r_clr_addr;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_valid;
    logic [SP_W-1:0]   r_index;
    logic [ROW_W-1:0]  r_wr_row;       // cell write held for the row update
    logic [COL_W-1:0]  r_wr_col;
    logic              r_wr_wall;

    // memories
    logic [MAX_COLS-1:0] r_wall_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_wall_q;
    logic                r_wall_q_vld;
    logic [SP_W-1:0]     r_mark_mem [MAX_ROWS*MAX_COLS];   // times a cell is on the path
    logic [SP_W-1:0]     r_mark_q;
    logic [CELL_W-1:0]   r_path_mem [STACK_DEPTH];
    logic [CELL_W-1:0]   r_path_q;
    logic [CELL_W-1:0]   r_alt_mem  [STACK_DEPTH];
    logic [CELL_W-1:0]   r_alt_q;

    // effective sizes, saturated to 1..MAX
    logic [6:0] eff_h, eff_w;
    always_comb begin
        eff_h = (r_height == 7'd0) ? 7'd1 : (r_height > 7'(MAX_ROWS) ? 7'(MAX_ROWS) : r_height);
        eff_w = (r_width  == 7'd0) ? 7'd1 : (r_width  > 7'(MAX_COLS) ? 7'(MAX_COLS) : r_width);
    end

    // neighbour coordinates of the current direction
    logic [ROW_W-1:0] nb_row;
    logic [COL_W-1:0] nb_col;
    logic             nb_in;
    always_comb begin
        nb_row = r_cur_row;
        nb_col = r_cur_col;
        nb_in  = 1'b0;
        case (r_dir)
            2'd0: begin
                nb_row = r_cur_row + 1'b1;
                nb_in  = ({1'b0, r_cur_row} + 7'd1) < eff_h;
            end
            2'd1: begin
                nb_row = r_cur_row - 1'b1;
                nb_in  = (r_cur_row != '0);
            end
            2'd2: begin
                nb_col = r_cur_col - 1'b1;
                nb_in  = (r_cur_col != '0);
            end
            default: begin
                nb_col = r_cur_col + 1'b1;
                nb_in  = ({1'b0, r_cur_col} + 7'd1) < eff_w;
            end
        endcase
    end

    // neighbour usable: inside the grid, open and not on the path
    logic nb_ok;
    assign nb_ok = nb_in && !(r_wall_q_vld && r_wall_q[nb_col]) && (r_mark_q == '0);

    // highest valid direction is chosen; alt_dir walks over the others
    logic [1:0] chosen;
    always_comb begin
        chosen = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (r_ok[i]) chosen = 2'(i);
        end
    end

    // next pending alternative: lowest set bit of r_ok other than chosen
    logic [3:0] alt_left;
    logic [1:0] alt_dir;
    always_comb begin
        alt_left = r_ok & ~(4'b0001 << chosen);
        alt_dir  = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (alt_left[i]) alt_dir = 2'(i);
        end
    end

    // exit test on the current top of path (r_wall_q holds its row)
    logic wall_bit;
    logic is_exit;
    assign wall_bit = r_wall_q_vld & r_wall_q[r_cur_col];
    always_comb begin
        is_exit = !wall_bit
            && !(r_cur_row == r_entry_row && r_cur_col == r_entry_col)
            && (r_cur_row == '0 || 7'(r_cur_row) == eff_h - 7'd1
                || r_cur_col == '0 || 7'(r_cur_col) == eff_w - 7'd1);
    end

    // adjacency of path top (r_path_q) to target alternative
    logic [ROW_W-1:0] pq_row;
    logic [COL_W-1:0] pq_col;
    logic             adj;
    assign pq_row = r_path_q[CELL_W-1:COL_W];
    assign pq_col = r_path_q[COL_W-1:0];
    always_comb begin
        adj = ((pq_col == r_tgt_col) && ((7'(pq_row) + 7'd1 == 7'(r_tgt_row))
                                      || (7'(r_tgt_row) + 7'd1 == 7'(pq_row))))
           || ((pq_row == r_tgt_row) && ((7'(pq_col) + 7'd1 == 7'(r_tgt_col))
                                      || (7'(r_tgt_col) + 7'd1 == 7'(pq_col))));
    end

    // ---------------- next state ----------------
    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_WRITE: n_state = ST_WR_CELL;
                        MODE_SOLVE: n_state = ST_CLEAR;
                        MODE_READ:  n_state = ST_RDP_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_WR_CELL: n_state = ST_DONE;
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    if (7'(r_entry_row) >= eff_h || 7'(r_entry_col) >= eff_w)
                        n_state = ST_DONE;
                    else
                        n_state = ST_TOP_RD;
                end
            end
            ST_TOP_RD:   n_state = ST_TOP_WAIT;
            ST_TOP_WAIT: n_state = ST_EXAM;
            ST_EXAM: begin
                if (is_exit || r_steps >= STEP_LIMIT) n_state = ST_DONE;
                else n_state = ST_NBR_RD;
            end
            ST_NBR_RD: n_state = nb_in ? ST_NBR_WAIT : ST_NBR_CHK;
            ST_NBR_WAIT: n_state = ST_NBR_CHK;
            ST_NBR_CHK: begin
                // the last direction's result is not in r_ok yet
                if (r_dir != 2'd3) n_state = ST_NBR_RD;
                else if ((r_ok | {nb_ok, 3'b000}) != 4'd0) n_state = ST_PUSH_CHOSEN;
                else if (r_alt_top != '0) n_state = ST_ALT_RD;
                else n_state = ST_DONE;
            end
            ST_PUSH_CHOSEN: n_state = (alt_left != 4'd0) ? ST_PUSH_ALT : ST_TOP_RD;
            ST_PUSH_ALT: begin
                // drop the alternative pushed in this cycle before deciding
                if ((alt_left & ~(4'b0001 << alt_dir)) != 4'd0) n_state = ST_PUSH_ALT;
                else n_state = ST_TOP_RD;
            end
            ST_ALT_RD:      n_state = ST_ALT_WAIT;
            ST_ALT_WAIT:    n_state = ST_UNW_RD;
            ST_UNW_RD:      n_state = (r_path_top == '0) ? ST_DONE : ST_UNW_WAIT;
            ST_UNW_WAIT:    n_state = ST_UNW_CHK;
            ST_UNW_CHK:     n_state = adj ? ST_PUSH_TGT : ST_UNW_RD;
            ST_PUSH_TGT:    n_state = ST_TOP_RD;
            ST_RDP_RD:      n_state = ST_RDP_WAIT;
            ST_RDP_WAIT:    n_state = ST_DONE;
            ST_DONE:        n_state = (r_out_valid && i_out_ready) ? ST_IDLE : ST_DONE;
            default:        n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_cfg_ready   = (r_state == ST_IDLE);
        o_out_valid   = r_out_valid;
        o_found       = r_found;
        o_path_length = r_path_top;
        o_path_row    = r_out_row;
        o_path_col    = r_out_col;
        o_overflow    = r_overflow;
    end

    // ---------------- memories ----------------
    // Path memory: write on push, read for top, unwind and path readback.
    logic              path_we;
    logic [SP_W-1:0]   path_wa, path_ra;
    logic [CELL_W-1:0] path_wd;
    logic              alt_we;
    logic [CELL_W-1:0] alt_wd;
    logic              mark_we;
    logic [SP_W-1:0]   mark_wd;
    logic [CELL_W-1:0] mark_wa, mark_ra;
    logic [ROW_W-1:0]  wall_ra;
    logic [ROW_W-1:0]  chosen_row, alt_row;
    logic [COL_W-1:0]  chosen_col, alt_col;

    function automatic logic [CELL_W-1:0] nbr_of(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c,
                                                 input logic [1:0] d);
        logic [CELL_W-1:0] v;
        case (d)
            2'd0:    v = {r + 1'b1, c};
            2'd1:    v = {r - 1'b1, c};
            2'd2:    v = {r, c - 1'b1};
            default: v = {r, c + 1'b1};
        endcase
        return v;
    endfunction

    assign {chosen_row, chosen_col} = nbr_of(r_cur_row, r_cur_col, chosen);
    assign {alt_row, alt_col}       = nbr_of(r_cur_row, r_cur_col, alt_dir);

    always_comb begin
        path_we = 1'b0;
        path_wa = r_path_top;
        path_wd = {chosen_row, chosen_col};
        path_ra = r_path_top - 1'b1;
        alt_we  = 1'b0;
        alt_wd  = {alt_row, alt_col};
        mark_we = 1'b0;
        mark_wd = SP_W'(1);
        mark_wa = {chosen_row, chosen_col};
        mark_ra = {nb_row, nb_col};
        wall_ra = nb_row;
        case (r_state)
            ST_IDLE: wall_ra = i_cell_row;
            ST_CLEAR: begin
                // clear every count, the entry starts on the path
                mark_we = 1'b1;
                mark_wd = (r_clr_addr == {r_entry_row, r_entry_col}) ? SP_W'(1) : '0;
                mark_wa = r_clr_addr;
                if (r_clr_addr == '1) begin
                    // push entry
                    path_we = 1'b1;
                    path_wa = '0;
                    path_wd = {r_entry_row, r_entry_col};
                end
            end
            ST_TOP_WAIT: wall_ra = r_path_q[CELL_W-1:COL_W];
            ST_PUSH_CHOSEN: begin
                path_we = (r_path_top < SP_FULL);
                mark_we = path_we;
            end
            ST_PUSH_ALT: alt_we = (r_alt_top < SP_FULL);
            ST_UNW_WAIT: mark_ra = r_path_q;
            ST_UNW_CHK: begin
                mark_ra = {r_tgt_row, r_tgt_col};
                if (!adj) begin
                    mark_we = 1'b1;
                    mark_wd = r_mark_q - 1'b1;
                    mark_wa = r_path_q;
                end
            end
            ST_PUSH_TGT: begin
                path_we = (r_path_top < SP_FULL);
                path_wd = {r_tgt_row, r_tgt_col};
                mark_we = path_we;
                mark_wd = r_mark_q + 1'b1;
                mark_wa = {r_tgt_row, r_tgt_col};
            end
            ST_RDP_RD: path_ra = r_index;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (path_we) r_path_mem[path_wa] <= path_wd;
        r_path_q <= r_path_mem[path_ra];
        if (alt_we) r_alt_mem[r_alt_top] <= alt_wd;
        r_alt_q <= r_alt_mem[r_alt_top - 1'b1];
        if (mark_we) r_mark_mem[mark_wa] <= mark_wd;
        r_mark_q <= r_mark_mem[mark_ra];
        // update the fetched row; an unwritten row starts open
        if (r_state == ST_WR_CELL) begin
            r_wall_mem[r_wr_row] <= ((r_wall_q_vld ? r_wall_q : '0)
                                     & ~(MAX_COLS'(1) << r_wr_col))
                                    | (MAX_COLS'(r_wr_wall) << r_wr_col);
        end
        r_wall_q     <= r_wall_mem[wall_ra];
        r_wall_q_vld <= r_row_valid[wall_ra];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_height    <= 7'(MAX_ROWS);
            r_width     <= 7'(MAX_COLS);
            r_entry_row <= '0;
            r_entry_col <= '0;
            r_row_valid <= '0;
            r_path_top  <= '0;
            r_alt_top   <= '0;
            r_found     <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_HEIGHT:    r_height    <= i_cfg_data;
                    REG_WIDTH:     r_width     <= i_cfg_data;
                    REG_ENTRY_ROW: r_entry_row <= i_cfg_data[ROW_W-1:0];
                    REG_ENTRY_COL: r_entry_col <= i_cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && t_mode'(i_mode) == MODE_SOLVE) begin
                        r_path_top <= '0;
                        r_alt_top  <= '0;
                        r_found    <= 1'b0;
                        r_overflow <= 1'b0;
                        r_clr_addr <= '0;
                    end
                end
                // hold the row valid bit once a row has been written
                ST_WR_CELL: r_row_valid[r_wr_row] <= 1'b1;
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1 &&
                        !(7'(r_entry_row) >= eff_h || 7'(r_entry_col) >= eff_w))
                        r_path_top <= SP_W'(1);
                end
                ST_EXAM: begin
                    if (is_exit) r_found <= 1'b1;
                end
                ST_PUSH_CHOSEN: begin
                    if (path_we) r_path_top <= r_path_top + 1'b1;
                    else r_overflow <= 1'b1;
                end
                ST_PUSH_ALT: begin
                    if (alt_we) r_alt_top <= r_alt_top + 1'b1;
                    else r_overflow <= 1'b1;
                end
                ST_ALT_RD: r_alt_top <= r_alt_top - 1'b1;
                ST_UNW_CHK: begin
                    if (!adj) r_path_top <= r_path_top - 1'b1;
                end
                ST_PUSH_TGT: begin
                    if (path_we) r_path_top <= r_path_top + 1'b1;
                    else r_overflow <= 1'b1;
                end
                default: ;
            endcase
            // raise the result once, drop it on delivery
            if (r_state != ST_DONE && n_state == ST_DONE)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_index   <= i_path_index;
                r_wr_row  <= i_cell_row;
                r_wr_col  <= i_cell_col;
                r_wr_wall <= i_wall;
                r_steps   <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end
            ST_TOP_WAIT: begin
                r_cur_row <= r_path_q[CELL_W-1:COL_W];
                r_cur_col <= r_path_q[COL_W-1:0];
            end
            ST_EXAM: begin
                r_steps <= r_steps + 1'b1;
                r_dir   <= 2'd0;
                r_ok    <= 4'd0;
            end
            ST_NBR_CHK: begin
                r_ok[r_dir] <= nb_ok;
                r_dir       <= r_dir + 1'b1;
            end
            ST_PUSH_ALT: r_ok[alt_dir] <= 1'b0;
            ST_ALT_WAIT: begin
                r_tgt_row <= r_alt_q[CELL_W-1:COL_W];
                r_tgt_col <= r_alt_q[COL_W-1:0];
            end
            ST_RDP_WAIT: begin
                if (r_index < r_path_top) begin
                    r_out_row <= r_path_q[CELL_W-1:COL_W];
                    r_out_col <= r_path_q[COL_W-1:0];
                end
            end
            default: ;
        endcase
        // in TOP_RD the path memory reads the top of path
    end

    // ---------------- assertions ----------------
    a_out_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_DONE) else $error("result outside done");
    a_found_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> r_path_top != '0) else $error("found with empty path");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_path_top <= SP_FULL && r_alt_top <= SP_FULL) else $error("stack bound");

endmodule

`default_nettype wire
